// ===== hdl/binary_window_threshold_filter_macros.svh =====
// ----------------------------------------------------------------------------
// binary window threshold filter assertion macros
// shared concurrent assertion forms for the filter's checker
// ----------------------------------------------------------------------------
`ifndef BINARY_WINDOW_THRESHOLD_FILTER_MACROS_SVH
`define BINARY_WINDOW_THRESHOLD_FILTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define BWTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bwtf assertion failed");

// next-cycle implication, disabled in reset
`define BWTF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bwtf assertion failed");

`endif

// ===== hdl/bwtf_pkg.sv =====
// ----------------------------------------------------------------------------
// bwtf_pkg
// shared constants and types of the binary window threshold filter
// ----------------------------------------------------------------------------
`default_nettype none

package bwtf_pkg;

  localparam int unsigned MaxSizeDef   = 64;
  localparam int unsigned WinRadiusDef = 3;

  localparam int unsigned RowW    = 64;
  localparam int unsigned SizeW   = 7;
  localparam int unsigned ThrW    = 6;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [SizeW-1:0] ResetSize = 7'd64;
  localparam logic [ThrW-1:0]  ResetThr  = 6'd30;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMapSize   = 1'b0,
    CfgThreshold = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    logic            done;
  } meta_t;

endpackage

`default_nettype wire

// ===== hdl/bwtf_window.sv =====
// ----------------------------------------------------------------------------
// bwtf_window
// row window, frame sequencer with end-of-frame flush, and registered
// per-column vertical counts
// ----------------------------------------------------------------------------
`default_nettype none

module bwtf_window #(
  parameter int unsigned MaxSize   = bwtf_pkg::MaxSizeDef,
  parameter int unsigned WinRadius = bwtf_pkg::WinRadiusDef,
  localparam int unsigned WinD     = 2 * WinRadius + 1,
  localparam int unsigned CntW     = $clog2(WinD + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [MaxSize-1:0]            row_i,
  input  wire logic [bwtf_pkg::SizeW-1:0]    eff_size_i,
  input  wire logic                          restart_i,
  output logic [MaxSize-1:0][CntW-1:0]       col_cnt_o,
  output bwtf_pkg::meta_t                    meta_o
);

  localparam int unsigned KW   = $clog2(WinRadius + 1);
  localparam int unsigned SumW = bwtf_pkg::SizeW + 1;

  logic [WinD-1:0][MaxSize-1:0] win_q, win_d;
  logic [bwtf_pkg::SizeW-1:0]   rr_q, rr_d;
  logic [bwtf_pkg::SizeW-1:0]   last_q, last_d;
  logic                         flush_q, flush_d;
  logic [KW-1:0]                k_q, k_d;
  logic [MaxSize-1:0][CntW-1:0] cnt_q, cnt_d;
  bwtf_pkg::meta_t              meta_q, meta_d;

  logic [bwtf_pkg::SizeW-1:0] cur_r;
  logic [MaxSize-1:0]         row_m;
  logic                       accept, step, is_last;
  logic [SumW-1:0]            pos;
  logic [KW-1:0]              cur_k;

  assign in_stall_o = flush_q || !adv_i;
  assign accept     = in_valid_i && adv_i && !flush_q;
  assign step       = flush_q && adv_i;
  assign cur_r      = (rr_q >= eff_size_i) ? '0 : rr_q;
  assign is_last    = (SumW'(cur_r) + SumW'(1)) >= SumW'(eff_size_i);

  always_comb begin
    for (int c = 0; c < MaxSize; c++) begin
      row_m[c] = row_i[c] && (bwtf_pkg::SizeW'(c) < eff_size_i);
    end
  end

  always_comb begin
    win_d = win_q;
    if (accept) begin
      if (cur_r == '0) begin
        win_d = '0;
      end else begin
        for (int i = 0; i < WinD - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
      end
      win_d[WinD-1] = row_m;
    end else if (step) begin
      for (int i = 0; i < WinD - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[WinD-1] = '0;
    end
  end

  always_comb begin
    rr_d    = rr_q;
    last_d  = last_q;
    flush_d = flush_q;
    k_d     = k_q;
    if (accept) begin
      if (is_last) begin
        rr_d    = '0;
        last_d  = cur_r;
        flush_d = 1'b1;
        k_d     = KW'(1);
      end else begin
        rr_d = cur_r + bwtf_pkg::SizeW'(1);
      end
    end else if (step) begin
      if (k_q == KW'(WinRadius)) begin
        flush_d = 1'b0;
      end else begin
        k_d = k_q + KW'(1);
      end
    end
    if (restart_i) begin
      rr_d = '0;
    end
  end

  // center row of the window is row (newest + k - radius)
  always_comb begin
    cur_k       = accept ? '0 : k_q;
    pos         = (accept ? SumW'(cur_r) : SumW'(last_q)) + SumW'(cur_k);
    meta_d.valid = (accept || step) && (pos >= SumW'(WinRadius));
    meta_d.idx   = bwtf_pkg::IdxW'(pos - SumW'(WinRadius));
    meta_d.done  = step && (k_q == KW'(WinRadius));
  end

  always_comb begin
    for (int c = 0; c < MaxSize; c++) begin
      cnt_d[c] = '0;
      for (int i = 0; i < WinD; i++) begin
        cnt_d[c] = cnt_d[c] + CntW'(win_d[i][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q    <= '0;
      last_q  <= '0;
      flush_q <= 1'b0;
      k_q     <= '0;
      meta_q  <= '0;
    end else begin
      rr_q    <= rr_d;
      last_q  <= last_d;
      flush_q <= flush_d;
      k_q     <= k_d;
      if (adv_i) begin
        meta_q <= meta_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (adv_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign col_cnt_o = cnt_q;
  assign meta_o    = meta_q;

endmodule

`default_nettype wire

// ===== hdl/bwtf_lane.sv =====
// ----------------------------------------------------------------------------
// bwtf_lane
// one output column: horizontal sum of column counts and threshold compare
// ----------------------------------------------------------------------------
`default_nettype none

module bwtf_lane #(
  parameter int unsigned MaxSize   = bwtf_pkg::MaxSizeDef,
  parameter int unsigned WinRadius = bwtf_pkg::WinRadiusDef,
  parameter int unsigned Col       = 0,
  localparam int unsigned WinD     = 2 * WinRadius + 1,
  localparam int unsigned CntW     = $clog2(WinD + 1)
) (
  input  wire logic [MaxSize-1:0][CntW-1:0]  col_cnt_i,
  input  wire logic [bwtf_pkg::ThrW-1:0]     thr_i,
  input  wire logic [bwtf_pkg::SizeW-1:0]    eff_size_i,
  output logic                               bit_o
);

  localparam int unsigned SumW = $clog2(WinD * WinD + 1);
  localparam int unsigned CmpW = (SumW > bwtf_pkg::ThrW) ? SumW : bwtf_pkg::ThrW;
  localparam int Lo = (int'(Col) >= int'(WinRadius)) ? int'(Col) - int'(WinRadius) : 0;
  localparam int Hi = (int'(Col) + int'(WinRadius) < int'(MaxSize)) ?
                      int'(Col) + int'(WinRadius) : int'(MaxSize) - 1;

  logic [SumW-1:0] sum;

  always_comb begin
    sum = '0;
    for (int j = Lo; j <= Hi; j++) begin
      sum = sum + SumW'(col_cnt_i[j]);
    end
  end

  assign bit_o = (CmpW'(sum) > CmpW'(thr_i)) &&
                 (bwtf_pkg::SizeW'(Col) < eff_size_i);

endmodule

`default_nettype wire

// ===== hdl/binary_window_threshold_filter.sv =====
// ----------------------------------------------------------------------------
// binary_window_threshold_filter
// thresholded window count over a square bit map, one row per beat
// ----------------------------------------------------------------------------
// an input beat is registered as column counts, then in the output register
// throughput: one row per cycle unless the output stalls; the last row of a
//   frame holds the input while the window drains (up to WinRadius+1 beats)
// the drain steps through the row window one shift per cycle unless the output stalls
// reset: control cleared, map size 64, threshold 30; row window refills at row 0
`default_nettype none

module binary_window_threshold_filter #(
  parameter int unsigned MaxSize   = bwtf_pkg::MaxSizeDef,
  parameter int unsigned WinRadius = bwtf_pkg::WinRadiusDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [bwtf_pkg::RowW-1:0]      row_bits_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [bwtf_pkg::IdxW-1:0]           out_row_index_o,
  output logic [bwtf_pkg::RowW-1:0]           out_bits_o,
  output logic                                frame_done_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bwtf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bwtf_pkg::SizeW-1:0]     cfg_wdata_i
);

  localparam int unsigned WinD = 2 * WinRadius + 1;
  localparam int unsigned CntW = $clog2(WinD + 1);

  logic [bwtf_pkg::SizeW-1:0]   size_q, eff_size;
  logic [bwtf_pkg::ThrW-1:0]    thr_q;
  logic                         adv, restart;
  logic [MaxSize-1:0][CntW-1:0] col_cnt;
  bwtf_pkg::meta_t              meta;
  logic [MaxSize-1:0]           lane_bits;

  logic                         out_valid_q;
  logic [bwtf_pkg::IdxW-1:0]    out_idx_q;
  logic [MaxSize-1:0]           out_bits_q;
  logic                         out_done_q;

  always_comb begin
    if (size_q == '0) begin
      eff_size = bwtf_pkg::SizeW'(1);
    end else if (size_q > bwtf_pkg::SizeW'(MaxSize)) begin
      eff_size = bwtf_pkg::SizeW'(MaxSize);
    end else begin
      eff_size = size_q;
    end
  end

  assign restart = cfg_we_i && (bwtf_pkg::cfg_reg_e'(cfg_idx_i) == bwtf_pkg::CfgMapSize);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= bwtf_pkg::ResetSize;
      thr_q  <= bwtf_pkg::ResetThr;
    end else if (cfg_we_i) begin
      unique case (bwtf_pkg::cfg_reg_e'(cfg_idx_i))
        bwtf_pkg::CfgMapSize:   size_q <= cfg_wdata_i;
        bwtf_pkg::CfgThreshold: thr_q  <= cfg_wdata_i[bwtf_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  assign adv = !out_valid_q || !out_stall_i;

  bwtf_window #(
    .MaxSize   (MaxSize),
    .WinRadius (WinRadius)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .row_i      (row_bits_i[MaxSize-1:0]),
    .eff_size_i (eff_size),
    .restart_i  (restart),
    .col_cnt_o  (col_cnt),
    .meta_o     (meta)
  );

  for (genvar c = 0; c < MaxSize; c++) begin : g_lane
    bwtf_lane #(
      .MaxSize   (MaxSize),
      .WinRadius (WinRadius),
      .Col       (c)
    ) u_lane (
      .col_cnt_i  (col_cnt),
      .thr_i      (thr_q),
      .eff_size_i (eff_size),
      .bit_o      (lane_bits[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= meta.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q  <= meta.idx;
      out_bits_q <= lane_bits;
      out_done_q <= meta.done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_index_o = out_idx_q;
  assign out_bits_o      = bwtf_pkg::RowW'(out_bits_q);
  assign frame_done_o    = out_done_q;

endmodule

`default_nettype wire

// ===== hdl/bwtf_checker.sv =====
// ----------------------------------------------------------------------------
// bwtf_checker
// port-level checks of the filter's output register and input backpressure
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_window_threshold_filter_macros.svh"

module bwtf_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [bwtf_pkg::IdxW-1:0]      out_row_index_o,
  input wire logic [bwtf_pkg::RowW-1:0]      out_bits_o,
  input wire logic                           frame_done_o
);

  `BWTF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_bits_o) && $stable(out_row_index_o) && $stable(frame_done_o))

  `BWTF_ASSERT_IMP(a_in_blocked, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o)

  `BWTF_ASSERT_IMP(a_out_drop, clk_i, rst_ni, $fell(out_valid_o), !$past(out_stall_i))

endmodule

bind binary_window_threshold_filter bwtf_checker u_bwtf_checker (.*);

`default_nettype wire
